// ===== design/f12ccw_pkg.sv =====
package f12ccw_pkg;

  // table size in bytes, 512 to 8192
  localparam int TABLE_BYTES = 8192;
  localparam int TABLE_AW    = $clog2(TABLE_BYTES);

  localparam logic [11:0] END_MARK = 12'hFF8;

  // configuration register indexes
  localparam logic CFG_REG_DATA_START = 1'b0;
  localparam logic CFG_REG_SPC        = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_START   = 2'd1,
    ACT_ADVANCE = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_END      = 2'd1,
    ST_BAD      = 2'd2,
    ST_NO_CHAIN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_JUDGE,
    S_EMIT
  } walk_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [12:0] table_index;
    logic [7:0]  table_byte;
    logic [11:0] start_cluster;
  } in_item_t;

  typedef struct packed {
    logic [11:0] cluster_number;
    logic [20:0] sector_address;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [19:0] data_start_lba;
    logic [7:0]  sectors_per_cluster;
  } cfg_t;

  // byte offset of the packed entry, c*3/2
  function automatic logic [13:0] entry_off(input logic [11:0] c);
    logic [13:0] tri_c;
    tri_c = {2'b00, c} + {1'b0, c, 1'b0};
    return {1'b0, tri_c[13:1]};
  endfunction

  // both entry bytes lie inside the table and the cluster is a data cluster
  function automatic logic in_table(input logic [11:0] c);
    logic [13:0] last;
    last = entry_off(c) + 14'd1;
    return (c >= 12'd2) && (last < 14'(TABLE_BYTES));
  endfunction

endpackage

// ===== design/f12ccw_ram.sv =====
module f12ccw_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en && !we) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/f12ccw_lba.sv =====
module f12ccw_lba
  import f12ccw_pkg::*;
(
  input  logic        clk,
  input  cfg_t        cfg,
  input  logic [11:0] cluster,
  output logic [20:0] lba_r
);

  logic [11:0] rel;
  logic [19:0] prod;
  logic [20:0] lba_nxt;

  always_comb begin
    rel     = cluster - 12'd2;
    prod    = {8'd0, rel} * {12'd0, cfg.sectors_per_cluster};
    lba_nxt = {1'b0, cfg.data_start_lba} + {1'b0, prod};
  end

  always_ff @(posedge clk) begin
    lba_r <= lba_nxt;
  end

endmodule

// ===== design/fat12_cluster_chain_walker_unit.sv =====
// fat12 cluster chain walker: holds a fat12 allocation table of TABLE_BYTES bytes in a
// single-port synchronous ram and walks cluster chains through it. a load transaction
// writes one table byte and finishes in its accept cycle (no result). a start transaction
// judges the given cluster and returns it with its first sector. an advance transaction
// reads the two table bytes of the current entry one after the other through the single
// ram port, unpacks the 12-bit entry, judges it and returns it, stepping through the
// states rd0, rd1, judge and emit; the sector multiplier is registered. an advance with
// no active chain skips the table reads and answers no chain. sector = data_start_lba +
// (cluster-2)*sectors_per_cluster, given only for status valid, else 0. end of chain is
// any value 0xff8 and up, bad cluster is below 2 or past the table. unused action codes
// are dropped. a finished result sits in the output register, so the next transaction is
// accepted while it waits. table bytes read before being loaded return garbage.
module fat12_cluster_chain_walker_unit
  import f12ccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata
);

  walk_state_t state_r, state_nxt;

  // configuration
  cfg_t cfg_r;

  // chain state
  logic [11:0] cur_cluster_r;
  logic        chain_active_r;

  // working registers for one transaction
  logic [11:0]         cand_r;
  status_t             status_r;
  logic [TABLE_AW-1:0] off_r;
  logic [7:0]          lo_r;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  // ram port
  logic                ram_en;
  logic                ram_we;
  logic [TABLE_AW-1:0] ram_addr;
  logic [7:0]          ram_wdata;
  logic [7:0]          ram_rdata;

  logic [20:0] lba;
  logic        in_acc;
  logic        emit_go;
  logic        load_ok;
  logic        adv_ok;
  logic [13:0] cur_off;
  logic [15:0] entry_word;
  logic [11:0] entry;
  status_t     judge_status;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // result register is free, or is being taken this cycle
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    load_ok    = ({1'b0, in_data.table_index} < 14'(TABLE_BYTES));
    cur_off    = entry_off(cur_cluster_r);
    adv_ok     = chain_active_r && in_table(cur_cluster_r);
    // little-endian word, second byte arrives now, first one was held
    entry_word = {ram_rdata, lo_r};
    entry      = cur_cluster_r[0] ? entry_word[15:4] : entry_word[11:0];
    if (cand_r >= END_MARK) begin
      judge_status = ST_END;
    end else if (!in_table(cand_r)) begin
      judge_status = ST_BAD;
    end else begin
      judge_status = ST_VALID;
    end
  end

  // sequencer: next state and ram port control
  always_comb begin
    state_nxt = state_r;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = off_r;
    ram_wdata = in_data.table_byte;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (action_t'(in_data.action))
            ACT_LOAD: begin
              ram_en   = load_ok;
              ram_we   = 1'b1;
              ram_addr = in_data.table_index[TABLE_AW-1:0];
            end
            ACT_START: begin
              state_nxt = S_JUDGE;
            end
            ACT_ADVANCE: begin
              if (adv_ok) begin
                // first entry byte
                ram_en    = 1'b1;
                ram_addr  = cur_off[TABLE_AW-1:0];
                state_nxt = S_RD0;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RD0: begin
        // second entry byte, in_table guarantees it is inside the table
        ram_en    = 1'b1;
        ram_addr  = off_r + TABLE_AW'(1);
        state_nxt = S_RD1;
      end
      S_RD1: begin
        state_nxt = S_JUDGE;
      end
      S_JUDGE: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_start_lba      <= 20'd33;
      cfg_r.sectors_per_cluster <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REG_DATA_START: cfg_r.data_start_lba      <= cfg_wdata;
        CFG_REG_SPC:        cfg_r.sectors_per_cluster <= cfg_wdata[7:0];
        default:            cfg_r                     <= cfg_r;
      endcase
    end
  end

  // chain state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cluster_r  <= 12'd0;
      chain_active_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (emit_go) begin
        if (status_r == ST_VALID) begin
          cur_cluster_r  <= cand_r;
          chain_active_r <= 1'b1;
        end else begin
          chain_active_r <= 1'b0;
        end
      end
    end
  end

  // transaction datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      off_r    <= cur_off[TABLE_AW-1:0];
      status_r <= ST_NO_CHAIN;
      if (action_t'(in_data.action) == ACT_ADVANCE && !adv_ok) begin
        cand_r <= 12'd0;
      end else begin
        cand_r <= in_data.start_cluster;
      end
    end
    if (state_r == S_RD0) begin
      lo_r <= ram_rdata;
    end
    if (state_r == S_RD1) begin
      cand_r <= entry;
    end
    if (state_r == S_JUDGE) begin
      status_r <= judge_status;
    end
    if (emit_go) begin
      out_data_r.cluster_number <= cand_r;
      out_data_r.sector_address <= (status_r == ST_VALID) ? lba : 21'd0;
      out_data_r.status         <= status_r;
    end
  end

  f12ccw_ram #(
    .DEPTH(TABLE_BYTES),
    .WIDTH(8)
  ) u_table (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // sector of cand_r, ready by the emit cycle
  f12ccw_lba u_lba (
    .clk    (clk),
    .cfg    (cfg_r),
    .cluster(cand_r),
    .lba_r  (lba)
  );

  // a new result appears only out of the emit step
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result appeared outside emit step");

  // a valid result makes its cluster current and the chain active
  a_chain_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && status_r == ST_VALID) |=> (chain_active_r && cur_cluster_r == $past(cand_r)))
    else $error("chain state not updated by valid result");

  // only a valid result carries a sector address
  a_sector_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_VALID) |-> (out_data_r.sector_address == 21'd0))
    else $error("sector address on non-valid result");

  // an advance with no chain skips the table reads
  a_no_chain_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action == ACT_ADVANCE && !chain_active_r) |=> (state_r == S_EMIT))
    else $error("advance without chain went to the table");

endmodule

// ===== verif/fat12_chain_checker.sv =====
`timescale 1ns / 100ps
module fat12_chain_checker
  import f12ccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        finished,
  output int          pending,
  output int          fail_count
);

  localparam logic [19:0] RESET_LBA = 20'd33;
  localparam logic [7:0]  RESET_SPC = 8'd1;

  logic [7:0]  fat_mem [TABLE_BYTES];
  logic [11:0] cur_clu;
  logic        walking;
  logic [19:0] lba_base;
  logic [7:0]  spc;
  out_item_t   hop_q [$];
  int          err_cnt = 0;
  bit          tail_checked = 1'b0;

  function automatic bit fits(input logic [11:0] c);
    return (c >= 12'd2) && ((int'(c) * 3) / 2 + 1 < TABLE_BYTES);
  endfunction

  // classify a cluster, queue its result and move the walk state
  task automatic judge(input logic [11:0] c);
    out_item_t   r;
    logic [31:0] sec;
    r.cluster_number = c;
    r.sector_address = '0;
    if (c >= END_MARK) begin
      r.status = ST_END;
      walking  = 1'b0;
    end else if (!fits(c)) begin
      r.status = ST_BAD;
      walking  = 1'b0;
    end else begin
      sec = 32'(lba_base) + (32'(c) - 32'd2) * 32'(spc);
      r.sector_address = sec[20:0];
      r.status = ST_VALID;
      cur_clu  = c;
      walking  = 1'b1;
    end
    hop_q.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    out_item_t   want;
    out_item_t   idle_hop;
    int          off;
    logic [15:0] word;
    if (!rst_n) begin
      cur_clu  = '0;
      walking  = 1'b0;
      lba_base = RESET_LBA;
      spc      = RESET_SPC;
      hop_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_REG_DATA_START) begin
          lba_base = cfg_wdata;
        end else if (cfg_index == CFG_REG_SPC) begin
          spc = cfg_wdata[7:0];
        end
      end

      // result side first: it belongs to an older transaction than any input at this edge
      if (out_valid && !out_stall) begin
        if (hop_q.size() == 0) begin
          $error("unexpected result: cluster_number %0d sector_address %0d status %0d",
                 out_data.cluster_number, out_data.sector_address, out_data.status);
          err_cnt++;
        end else begin
          want = hop_q.pop_front();
          if (out_data.cluster_number !== want.cluster_number) begin
            $error("cluster_number mismatch: expected %0d, actual %0d",
                   want.cluster_number, out_data.cluster_number);
            err_cnt++;
          end
          if (out_data.sector_address !== want.sector_address) begin
            $error("sector_address mismatch: expected %0d, actual %0d",
                   want.sector_address, out_data.sector_address);
            err_cnt++;
          end
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_data.status);
            err_cnt++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        case (action_t'(in_data.action))
          ACT_LOAD: begin
            if (int'(in_data.table_index) < TABLE_BYTES) begin
              fat_mem[in_data.table_index] = in_data.table_byte;
            end
          end
          ACT_START: judge(in_data.start_cluster);
          ACT_ADVANCE: begin
            if (!walking || !fits(cur_clu)) begin
              walking = 1'b0;
              idle_hop.cluster_number = '0;
              idle_hop.sector_address = '0;
              idle_hop.status         = ST_NO_CHAIN;
              hop_q.push_back(idle_hop);
            end else begin
              off  = (int'(cur_clu) * 3) / 2;
              word = {fat_mem[off + 1], fat_mem[off]};
              judge(cur_clu[0] ? word[15:4] : word[11:0]);
            end
          end
          default: ;
        endcase
      end

      if (finished && !tail_checked) begin
        tail_checked = 1'b1;
        if (hop_q.size() != 0) begin
          $error("%0d expected results never arrived", hop_q.size());
          err_cnt += hop_q.size();
        end
      end
    end
    pending    <= hop_q.size();
    fail_count <= err_cnt;
  end

endmodule

// ===== verif/tb_fat12_cluster_chain_walker_unit.sv =====
`timescale 1ns / 100ps
module tb_fat12_cluster_chain_walker_unit;
  import f12ccw_pkg::*;

  // random transactions per configuration phase, seven phases
  localparam int PHASE_ITEMS   = 255;
  // an advance walks through the table-read states; loads finish at accept, so give a margin
  localparam int SETTLE_CYCLES = 12;
  // long receiver hold-off so the block backs up into its input
  localparam int LONG_HOLD     = 150;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        out_stall = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_REG_DATA_START;
  logic [19:0] cfg_wdata = '0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_data;

  logic        finished  = 1'b0;
  int          pending;
  int          fail_count;
  int          hold_req  = 0;

  // stimulus-side view of the table and the walk, only used to keep advances legal
  // (an advance must never read a table byte that was never loaded)
  bit [7:0]    img    [TABLE_BYTES];
  bit          loaded [TABLE_BYTES];
  logic [11:0] walk_at = '0;
  bit          walk_on = 1'b0;
  int          n_items = 0;
  int          burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fat12_cluster_chain_walker_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fat12_chain_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .finished   (finished),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // hard stop in case the block hangs
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: stretches of no stall, light stall, heavy stall and toggling,
  // plus a long hold-off whenever the sender asks for one
  initial begin : rx_pattern
    int mode;
    int len;
    int holds_done;
    holds_done = 0;
    forever begin
      if (hold_req != holds_done) begin
        holds_done++;
        repeat (LONG_HOLD) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 80);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  function automatic bit fits(input logic [11:0] c);
    return (c >= 12'd2) && ((int'(c) * 3) / 2 + 1 < TABLE_BYTES);
  endfunction

  // move the stimulus-side walk to cluster c
  function automatic void follow(input logic [11:0] c);
    walk_on = (c < END_MARK) && fits(c);
    if (walk_on) walk_at = c;
  endfunction

  // track what a transaction does to the table and the walk
  function automatic void track(input in_item_t it);
    int          off;
    logic [15:0] word;
    case (action_t'(it.action))
      ACT_LOAD: begin
        if (int'(it.table_index) < TABLE_BYTES) begin
          img[it.table_index]    = it.table_byte;
          loaded[it.table_index] = 1'b1;
        end
      end
      ACT_START: follow(it.start_cluster);
      ACT_ADVANCE: begin
        if (walk_on) begin
          off  = (int'(walk_at) * 3) / 2;
          word = {img[off + 1], img[off]};
          follow(walk_at[0] ? word[15:4] : word[11:0]);
        end
      end
      default: ;
    endcase
  endfunction

  // all fields random, every bit of every field gets exercised
  function automatic in_item_t noise_fields();
    in_item_t it;
    it.action        = 2'($urandom_range(0, 3));
    it.table_index   = 13'($urandom);
    it.table_byte    = 8'($urandom);
    it.start_cluster = 12'($urandom);
    return it;
  endfunction

  // next-cluster value for a table entry: mostly a small pool so chains revisit
  // clusters, some far clusters, end markers, bad clusters and raw values
  function automatic logic [11:0] pick_link();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 12'($urandom_range(2, 40));
    if (r < 77) return 12'($urandom_range(2, int'(END_MARK) - 1));
    if (r < 87) return 12'($urandom_range(int'(END_MARK), 4095));
    if (r < 93) return 12'($urandom_range(0, 1));
    return 12'($urandom);
  endfunction

  // one transaction on the input channel; bursts with random gaps between them
  task automatic offer(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    track(it);
    if (it.action != ACT_UNUSED) n_items++;
  endtask

  task automatic load_byte(input logic [12:0] idx, input logic [7:0] val);
    in_item_t it;
    it             = noise_fields();
    it.action      = ACT_LOAD;
    it.table_index = idx;
    it.table_byte  = val;
    offer(it);
  endtask

  task automatic start_at(input logic [11:0] c);
    in_item_t it;
    it               = noise_fields();
    it.action        = ACT_START;
    it.start_cluster = c;
    offer(it);
  endtask

  // write the packed 12-bit entry of cluster c, keeping the neighbor's nibble
  task automatic set_link(input logic [11:0] c, input logic [11:0] val);
    int         off;
    logic [7:0] lo;
    logic [7:0] hi;
    off = (int'(c) * 3) / 2;
    if (c[0]) begin
      lo = {val[3:0], img[off][3:0]};
      hi = val[11:4];
    end else begin
      lo = val[7:0];
      hi = {img[off + 1][7:4], val[11:8]};
    end
    load_byte(13'(off), lo);
    load_byte(13'(off + 1), hi);
  endtask

  // an advance; the entry it will read gets loaded first if it never was
  task automatic advance_chain();
    in_item_t it;
    int       off;
    if (walk_on) begin
      off = (int'(walk_at) * 3) / 2;
      if (!loaded[off] || !loaded[off + 1]) set_link(walk_at, pick_link());
    end
    it        = noise_fields();
    it.action = ACT_ADVANCE;
    offer(it);
  endtask

  // well-formed walk: a start, then a run of advances, relinking entries on the way;
  // advances past the end of a chain give the no-chain answer
  task automatic run_chain();
    int hops;
    start_at(($urandom_range(0, 4) == 0) ? 12'($urandom) : pick_link());
    hops = $urandom_range(1, 12);
    repeat (hops) begin
      if (walk_on && $urandom_range(0, 2) == 0) set_link(walk_at, pick_link());
      advance_chain();
    end
  endtask

  // stop offering, wait for every expected result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, only while the block is idle
  task automatic set_geometry(input logic [19:0] lba, input logic [7:0] spc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REG_DATA_START;
    cfg_wdata <= lba;
    @(posedge clk);
    cfg_index <= CFG_REG_SPC;
    cfg_wdata <= {12'd0, spc};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(input int count, input bit squeeze);
    in_item_t it;
    int       goal;
    bit       held;
    goal = n_items + count;
    held = 1'b0;
    while (n_items < goal) begin
      // halfway through, ask the receiver for a long hold-off while we keep sending
      if (squeeze && !held && n_items >= goal - count / 2) begin
        hold_req <= hold_req + 1;
        held = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        run_chain();
      end else begin
        it = noise_fields();
        if (it.action == ACT_ADVANCE) advance_chain();
        else offer(it);
      end
    end
  endtask

  // directed cases under the reset geometry
  task automatic directed();
    in_item_t it;
    advance_chain();                     // advance before any start: no chain
    load_byte(13'h1FFF, 8'hFF);          // top table byte, all ones
    load_byte(13'h0000, 8'h00);          // bottom table byte, all zeros
    start_at(12'd0);                     // below the data region: bad
    start_at(12'd1);
    start_at(12'hFFF);                   // end markers as start cluster
    start_at(END_MARK);
    advance_chain();                     // chain ended: no chain
    set_link(12'd2, 12'd3);              // even entry
    set_link(12'd3, END_MARK - 12'd1);   // odd entry sharing a byte with the even one
    set_link(END_MARK - 12'd1, 12'hFFF); // last usable cluster points to end
    start_at(12'd2);
    advance_chain();                     // 2 -> 3
    advance_chain();                     // 3 -> last usable cluster
    advance_chain();                     // -> end of chain
    advance_chain();                     // no chain
    set_link(12'd4, 12'd1);              // entry leading to a bad cluster
    start_at(12'd4);
    advance_chain();
    it        = noise_fields();          // unused action code is dropped
    it.action = ACT_UNUSED;
    offer(it);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    settle();
    set_geometry(20'd0, 8'd0);           // zero sectors per cluster
    random_phase(PHASE_ITEMS, 1'b0);
    settle();
    set_geometry(20'hFFFFF, 8'd255);     // both registers at their top
    random_phase(PHASE_ITEMS, 1'b1);
    settle();
    set_geometry(20'd0, 8'd1);           // smallest usable geometry
    random_phase(PHASE_ITEMS, 1'b0);
    settle();
    set_geometry(20'hFFFFF, 8'd128);
    random_phase(PHASE_ITEMS, 1'b1);
    repeat (3) begin
      settle();
      set_geometry(20'($urandom), 8'($urandom_range(1, 128)));
      random_phase(PHASE_ITEMS, 1'b0);
    end
    settle();

    finished <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/f12ccw_pkg.sv
design/f12ccw_ram.sv
design/f12ccw_lba.sv
design/fat12_cluster_chain_walker_unit.sv
verif/fat12_chain_checker.sv
verif/tb_fat12_cluster_chain_walker_unit.sv
